[sv/pstt_pkg.sv]
// Shared types, codes and defaults of the periodic task scheduler table.
`default_nettype none
package pstt_pkg;

   localparam int NUM_SLOTS_DEF = 8;
   localparam int TICK_MS_DEF   = 10;

   localparam int MODE_W    = 2;
   localparam int HANDLE_W  = 16;
   localparam int TIME_W    = 32;
   localparam int SLOT_W    = 4;
   localparam int STATUS_W  = 2;
   localparam int PENDING_W = 8;

   localparam logic [MODE_W-1:0] MODE_TICK     = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ADD      = 2'd1;
   localparam logic [MODE_W-1:0] MODE_DELETE   = 2'd2;
   localparam logic [MODE_W-1:0] MODE_DISPATCH = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL       = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_SLOT   = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_NONE_READY = 2'd3;

   localparam logic KIND_STATUS = 1'b0;
   localparam logic KIND_TASK   = 1'b1;

   localparam logic [PENDING_W-1:0] PENDING_MAX = 8'hFF;

   typedef struct packed {
      logic [MODE_W-1:0]   mode;
      logic [HANDLE_W-1:0] task_handle;
      logic [TIME_W-1:0]   delay_ms;
      logic [TIME_W-1:0]   period_ms;
      logic [SLOT_W-1:0]   slot_index;
   } req_type;

   typedef struct packed {
      logic                kind;
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   result_slot;
      logic [HANDLE_W-1:0] result_handle;
      logic                last;
   } rsp_type;

   typedef struct packed {
      logic                 valid;
      logic [HANDLE_W-1:0]  handle;
      logic [TIME_W-1:0]    delay;
      logic [TIME_W-1:0]    period;
      logic [PENDING_W-1:0] pending;
   } slot_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TICK,
      ST_DIV_DELAY,
      ST_DIV_PERIOD,
      ST_SHIFT,
      ST_DISP,
      ST_DISP_END
   } state_type;

endpackage
`default_nettype wire

[sv/periodic_task_scheduler_table.sv]
// Top level of the periodic task scheduler table: command sequencer.
//
// A command beat is taken at a clock edge with start high and busy low.
// Results leave on rsp for one cycle each, marked by rsp_valid; the receiver
// cannot stall them. Every command ends with a result marked last.
// Commands, with N = NUM_SLOTS, one slot walked per cycle:
//   tick     : walks all N slots, then one ok status.
//   add      : two divides by TICK_MS, each a reciprocal multiply
//              step and a correction step through the shared subtractor;
//              a full table answers with a full status and no divide.
//   delete   : compaction from the deleted slot to the end, one slot moved per
//              cycle; a bad slot answers with a bad-slot status.
//   dispatch : a scan over the slots, plus for each one-shot task removed a
//              compaction and a second look at the slot that moved in,
//              plus a closing step. One result per ready task,
//              the last marked, or one nothing-ready status.
// A result appears the cycle after it is produced; busy drops as the final
// result is registered. The subtractor, the multiplier and the single slot
// read port shape the steps above. Reset empties the table and idles the
// sequencer.
`default_nettype none
module periodic_task_scheduler_table #(
   parameter int NUM_SLOTS = pstt_pkg::NUM_SLOTS_DEF,
   parameter int TICK_MS   = pstt_pkg::TICK_MS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  pstt_pkg::req_type req,
   output logic             rsp_valid,
   output pstt_pkg::rsp_type rsp
);

   localparam int IDXW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam logic [IDXW-1:0] LAST_IDX = IDXW'(NUM_SLOTS - 1);
   localparam int PW      = 2 * pstt_pkg::TIME_W;
   localparam int DIV_L   = $clog2(TICK_MS);
   localparam int DIV_SH1 = (DIV_L > 0) ? 1 : 0;
   localparam int DIV_SH2 = (DIV_L > 1) ? DIV_L - 1 : 0;
   localparam logic [PW-1:0] DIV_M64 =
      (((PW'(1) << DIV_L) - PW'(TICK_MS)) << pstt_pkg::TIME_W) / PW'(TICK_MS) + PW'(1);
   localparam logic [pstt_pkg::TIME_W-1:0] DIV_M = pstt_pkg::TIME_W'(DIV_M64);

   pstt_pkg::state_type state_ff, state_in;
   pstt_pkg::req_type   req_ff, req_in;
   pstt_pkg::rsp_type   rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [IDXW-1:0]     ptr_ff, ptr_in;
   logic [IDXW-1:0]     disp_ptr_ff, disp_ptr_in;
   logic                from_disp_ff, from_disp_in;
   logic [IDXW-1:0]     free_ff, free_in;
   logic [pstt_pkg::TIME_W-1:0] dq_ff, dq_in;
   logic [pstt_pkg::TIME_W-1:0] prod_ff, prod_in;
   logic                phase_ff, phase_in;
   logic [pstt_pkg::TIME_W-1:0] delay_q_ff, delay_q_in;
   logic                hold_valid_ff, hold_valid_in;
   logic [IDXW-1:0]     hold_slot_ff, hold_slot_in;
   logic [pstt_pkg::HANDLE_W-1:0] hold_handle_ff, hold_handle_in;

   logic [IDXW-1:0]      rd_idx, wr_idx;
   pstt_pkg::slot_type   rd_entry, wr_entry;
   logic                 wr_en;
   logic [NUM_SLOTS-1:0] valid_vec;

   logic [pstt_pkg::TIME_W-1:0] sub_a, sub_b, sub_diff, quot;
   logic                        sub_borrow, dividing;
   logic [PW-1:0]               prod_full;

   logic            have_free;
   logic [IDXW-1:0] free_idx;
   logic            del_ok;
   logic            found;

   pstt_slots #(.NUM_SLOTS(NUM_SLOTS)) u_slots (
      .clock     (clock),
      .reset     (reset),
      .rd_idx    (rd_idx),
      .rd_entry  (rd_entry),
      .wr_en     (wr_en),
      .wr_idx    (wr_idx),
      .wr_entry  (wr_entry),
      .valid_vec (valid_vec)
   );

   pstt_sub u_sub (
      .a      (sub_a),
      .b      (sub_b),
      .diff   (sub_diff),
      .borrow (sub_borrow)
   );

   assign dividing  = (state_ff == pstt_pkg::ST_DIV_DELAY) ||
                      (state_ff == pstt_pkg::ST_DIV_PERIOD);
   assign prod_full = PW'(dq_ff) * PW'(DIV_M);
   assign sub_a     = dividing ? dq_ff : rd_entry.delay;
   assign sub_b     = dividing ? prod_ff : pstt_pkg::TIME_W'(1);
   assign quot      = (prod_ff + (sub_diff >> DIV_SH1)) >> DIV_SH2;

   always_comb begin
      have_free = 1'b0;
      free_idx  = '0;
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (!valid_vec[i]) begin
            have_free = 1'b1;
            free_idx  = IDXW'(i);
         end
      end
   end

   assign del_ok = ({1'b0, req.slot_index} < (pstt_pkg::SLOT_W + 1)'(NUM_SLOTS)) &&
                   valid_vec[req.slot_index[IDXW-1:0]];
   assign found  = rd_entry.valid && (rd_entry.pending != '0);

   assign rd_idx = ((state_ff == pstt_pkg::ST_SHIFT) && (ptr_ff != LAST_IDX)) ?
                   ptr_ff + IDXW'(1) : ptr_ff;
   assign wr_idx = (state_ff == pstt_pkg::ST_DIV_PERIOD) ? free_ff : ptr_ff;

   always_comb begin
      state_in       = state_ff;
      req_in         = req_ff;
      rsp_in         = rsp_ff;
      rsp_valid_in   = 1'b0;
      ptr_in         = ptr_ff;
      disp_ptr_in    = disp_ptr_ff;
      from_disp_in   = from_disp_ff;
      free_in        = free_ff;
      dq_in          = dq_ff;
      prod_in        = prod_ff;
      phase_in       = phase_ff;
      delay_q_in     = delay_q_ff;
      hold_valid_in  = hold_valid_ff;
      hold_slot_in   = hold_slot_ff;
      hold_handle_in = hold_handle_ff;
      wr_en          = 1'b0;
      wr_entry       = rd_entry;

      unique case (state_ff)
         pstt_pkg::ST_IDLE: begin
            if (start) begin
               req_in = req;
               unique case (req.mode)
                  pstt_pkg::MODE_TICK: begin
                     ptr_in   = '0;
                     state_in = pstt_pkg::ST_TICK;
                  end
                  pstt_pkg::MODE_ADD: begin
                     if (have_free) begin
                        free_in  = free_idx;
                        dq_in    = req.delay_ms;
                        phase_in = 1'b0;
                        state_in = pstt_pkg::ST_DIV_DELAY;
                     end else begin
                        rsp_valid_in = 1'b1;
                        rsp_in = '{kind: pstt_pkg::KIND_STATUS, status: pstt_pkg::STATUS_FULL,
                                   result_slot: '0, result_handle: '0, last: 1'b1};
                     end
                  end
                  pstt_pkg::MODE_DELETE: begin
                     if (del_ok) begin
                        ptr_in       = req.slot_index[IDXW-1:0];
                        from_disp_in = 1'b0;
                        state_in     = pstt_pkg::ST_SHIFT;
                     end else begin
                        rsp_valid_in = 1'b1;
                        rsp_in = '{kind: pstt_pkg::KIND_STATUS,
                                   status: pstt_pkg::STATUS_BAD_SLOT,
                                   result_slot: req.slot_index, result_handle: '0,
                                   last: 1'b1};
                     end
                  end
                  pstt_pkg::MODE_DISPATCH: begin
                     ptr_in        = '0;
                     hold_valid_in = 1'b0;
                     state_in      = pstt_pkg::ST_DISP;
                  end
                  default: ;
               endcase
            end
         end

         pstt_pkg::ST_TICK: begin
            if (rd_entry.valid) begin
               wr_en = 1'b1;
               if (sub_borrow) begin
                  wr_entry.delay = rd_entry.period;
                  if (rd_entry.pending != pstt_pkg::PENDING_MAX) begin
                     wr_entry.pending = rd_entry.pending + pstt_pkg::PENDING_W'(1);
                  end
               end else begin
                  wr_entry.delay = sub_diff;
               end
            end
            if (ptr_ff == LAST_IDX) begin
               rsp_valid_in = 1'b1;
               rsp_in = '{kind: pstt_pkg::KIND_STATUS, status: pstt_pkg::STATUS_OK,
                          result_slot: '0, result_handle: '0, last: 1'b1};
               state_in = pstt_pkg::ST_IDLE;
            end else begin
               ptr_in = ptr_ff + IDXW'(1);
            end
         end

         pstt_pkg::ST_DIV_DELAY: begin
            if (!phase_ff) begin
               prod_in  = prod_full[PW-1:pstt_pkg::TIME_W];
               phase_in = 1'b1;
            end else begin
               delay_q_in = quot;
               dq_in      = req_ff.period_ms;
               phase_in   = 1'b0;
               state_in   = pstt_pkg::ST_DIV_PERIOD;
            end
         end

         pstt_pkg::ST_DIV_PERIOD: begin
            if (!phase_ff) begin
               prod_in  = prod_full[PW-1:pstt_pkg::TIME_W];
               phase_in = 1'b1;
            end else begin
               phase_in = 1'b0;
               wr_en    = 1'b1;
               wr_entry = '{valid: 1'b1, handle: req_ff.task_handle, delay: delay_q_ff,
                            period: quot, pending: '0};
               rsp_valid_in = 1'b1;
               rsp_in = '{kind: pstt_pkg::KIND_STATUS, status: pstt_pkg::STATUS_OK,
                          result_slot: pstt_pkg::SLOT_W'(free_ff), result_handle: '0,
                          last: 1'b1};
               state_in = pstt_pkg::ST_IDLE;
            end
         end

         pstt_pkg::ST_SHIFT: begin
            wr_en = 1'b1;
            if (ptr_ff == LAST_IDX) begin
               wr_entry = '0;
               if (from_disp_ff) begin
                  ptr_in   = disp_ptr_ff;
                  state_in = pstt_pkg::ST_DISP;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_in = '{kind: pstt_pkg::KIND_STATUS, status: pstt_pkg::STATUS_OK,
                             result_slot: req_ff.slot_index, result_handle: '0,
                             last: 1'b1};
                  state_in = pstt_pkg::ST_IDLE;
               end
            end else begin
               ptr_in = ptr_ff + IDXW'(1);
            end
         end

         pstt_pkg::ST_DISP: begin
            if (found) begin
               wr_en            = 1'b1;
               wr_entry.pending = rd_entry.pending - pstt_pkg::PENDING_W'(1);
               if (hold_valid_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_in = '{kind: pstt_pkg::KIND_TASK, status: pstt_pkg::STATUS_OK,
                             result_slot: pstt_pkg::SLOT_W'(hold_slot_ff),
                             result_handle: hold_handle_ff, last: 1'b0};
               end
               hold_valid_in  = 1'b1;
               hold_slot_in   = ptr_ff;
               hold_handle_in = rd_entry.handle;
            end
            if (found && (rd_entry.period == '0)) begin
               disp_ptr_in  = ptr_ff;
               from_disp_in = 1'b1;
               state_in     = pstt_pkg::ST_SHIFT;
            end else if (ptr_ff == LAST_IDX) begin
               state_in = pstt_pkg::ST_DISP_END;
            end else begin
               ptr_in = ptr_ff + IDXW'(1);
            end
         end

         pstt_pkg::ST_DISP_END: begin
            rsp_valid_in = 1'b1;
            if (hold_valid_ff) begin
               rsp_in = '{kind: pstt_pkg::KIND_TASK, status: pstt_pkg::STATUS_OK,
                          result_slot: pstt_pkg::SLOT_W'(hold_slot_ff),
                          result_handle: hold_handle_ff, last: 1'b1};
            end else begin
               rsp_in = '{kind: pstt_pkg::KIND_STATUS, status: pstt_pkg::STATUS_NONE_READY,
                          result_slot: '0, result_handle: '0, last: 1'b1};
            end
            hold_valid_in = 1'b0;
            state_in      = pstt_pkg::ST_IDLE;
         end

         default: state_in = pstt_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= pstt_pkg::ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         hold_valid_ff <= 1'b0;
         from_disp_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         hold_valid_ff <= hold_valid_in;
         from_disp_ff  <= from_disp_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff         <= req_in;
      rsp_ff         <= rsp_in;
      ptr_ff         <= ptr_in;
      disp_ptr_ff    <= disp_ptr_in;
      free_ff        <= free_in;
      dq_ff          <= dq_in;
      prod_ff        <= prod_in;
      phase_ff       <= phase_in;
      delay_q_ff     <= delay_q_in;
      hold_slot_ff   <= hold_slot_in;
      hold_handle_ff <= hold_handle_in;
   end

   assign busy      = (state_ff != pstt_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule
`default_nettype wire

[sv/pstt_sub.sv]
// Shared 32-bit subtractor: tick countdown and divide correction steps.
`default_nettype none
module pstt_sub (
   input  wire logic [pstt_pkg::TIME_W-1:0] a,
   input  wire logic [pstt_pkg::TIME_W-1:0] b,
   output logic      [pstt_pkg::TIME_W-1:0] diff,
   output logic                             borrow
);

   logic [pstt_pkg::TIME_W:0] full;

   assign full   = {1'b0, a} - {1'b0, b};
   assign diff   = full[pstt_pkg::TIME_W-1:0];
   assign borrow = full[pstt_pkg::TIME_W];

endmodule
`default_nettype wire

[sv/pstt_slots.sv]
// Task slot storage: one read port, one write port, valid bits cleared by reset.
`default_nettype none
module pstt_slots #(
   parameter  int NUM_SLOTS = pstt_pkg::NUM_SLOTS_DEF,
   localparam int IDXW      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [IDXW-1:0]    rd_idx,
   output pstt_pkg::slot_type      rd_entry,
   input  wire logic               wr_en,
   input  wire logic [IDXW-1:0]    wr_idx,
   input  pstt_pkg::slot_type      wr_entry,
   output logic [NUM_SLOTS-1:0]    valid_vec
);

   logic [NUM_SLOTS-1:0] valid_ff;
   logic [pstt_pkg::HANDLE_W-1:0]  handle_ff  [NUM_SLOTS];
   logic [pstt_pkg::TIME_W-1:0]    delay_ff   [NUM_SLOTS];
   logic [pstt_pkg::TIME_W-1:0]    period_ff  [NUM_SLOTS];
   logic [pstt_pkg::PENDING_W-1:0] pending_ff [NUM_SLOTS];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_idx] <= wr_entry.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         handle_ff[wr_idx]  <= wr_entry.handle;
         delay_ff[wr_idx]   <= wr_entry.delay;
         period_ff[wr_idx]  <= wr_entry.period;
         pending_ff[wr_idx] <= wr_entry.pending;
      end
   end

   assign rd_entry.valid   = valid_ff[rd_idx];
   assign rd_entry.handle  = handle_ff[rd_idx];
   assign rd_entry.delay   = delay_ff[rd_idx];
   assign rd_entry.period  = period_ff[rd_idx];
   assign rd_entry.pending = pending_ff[rd_idx];
   assign valid_vec        = valid_ff;

endmodule
`default_nettype wire

[sv/pstt_checker.sv]
// Port-level checks of the scheduler table, bound to the top level.
`default_nettype none
module pstt_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              start,
   input wire logic              busy,
   input pstt_pkg::req_type      req,
   input wire logic              rsp_valid,
   input pstt_pkg::rsp_type      rsp
);

   a_tick_goes_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req.mode == pstt_pkg::MODE_TICK) |=> busy)
      else $error("tick beat did not start a slot walk");

   a_status_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp.kind == pstt_pkg::KIND_STATUS) |-> rsp.last && (rsp.result_handle == '0))
      else $error("status beat not last or carries a handle");

   a_task_status_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp.kind == pstt_pkg::KIND_TASK) |-> (rsp.status == pstt_pkg::STATUS_OK))
      else $error("dispatched task beat with non-ok status");

   a_more_follows_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp.last |-> busy)
      else $error("non-last beat while sequencer idle");

endmodule

bind periodic_task_scheduler_table pstt_checker u_pstt_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req       (req),
   .rsp_valid (rsp_valid),
   .rsp       (rsp)
);
`default_nettype wire
